// ----- hw/rtl/dq_pkg.sv -----
package dq_pkg;

	localparam int DEPTH_DEF = 64;
	localparam int DATA_W    = 32;
	localparam int REQ_W     = 2;
	localparam int STAT_W    = 2;
	localparam int FILL_W    = 7;

	typedef enum logic [REQ_W-1:0] {
		REQ_PUSH_FRONT = 2'd0,
		REQ_PUSH_REAR  = 2'd1,
		REQ_POP_FRONT  = 2'd2,
		REQ_POP_REAR   = 2'd3
	} req_t;

	typedef enum logic [STAT_W-1:0] {
		ST_DONE  = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_FETCH,
		S_LOAD
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic latch_req;
		logic exec;
		logic capture_removed;
		logic load_out;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic out_busy;
	} dp_sts_t;

endpackage

// ----- hw/rtl/dq_if.sv -----
interface dq_req_if;
	logic                              valid;
	logic                              ready;
	logic [dq_pkg::REQ_W-1:0]          req_type;
	logic signed [dq_pkg::DATA_W-1:0]  value;

	modport source (output valid, output req_type, output value, input ready);
	modport sink (input valid, input req_type, input value, output ready);
endinterface

interface dq_rsp_if;
	logic                              valid;
	logic                              ready;
	logic signed [dq_pkg::DATA_W-1:0]  removed_value;
	logic [dq_pkg::STAT_W-1:0]         status;
	logic signed [dq_pkg::DATA_W-1:0]  front_value;
	logic signed [dq_pkg::DATA_W-1:0]  rear_value;
	logic                              is_empty;
	logic [dq_pkg::FILL_W-1:0]         fill_count;

	modport source (output valid, output removed_value, output status, output front_value,
		output rear_value, output is_empty, output fill_count, input ready);
	modport sink (input valid, input removed_value, input status, input front_value,
		input rear_value, input is_empty, input fill_count, output ready);
endinterface

// ----- hw/rtl/double_ended_queue_top.sv -----
// Channel  Direction  Payload                                              Beat when
// req      in         req_type[1:0], value[31:0]                           valid && ready
// rsp      out        removed_value, status, front_value, rear_value,      valid && ready
//                     is_empty, fill_count[6:0]
//
// Each request steps through accept, execute (entry write or removal read), a
// two-port read of the new front and rear entries, and the load of the result register.
// The entry memory with its registered read ports sets these steps.
// Reset (arst_n low) empties the queue at once; the entry memory itself is not cleared.
// A result waits in its register until taken; a new request is accepted meanwhile, and
// only its final load stalls while the earlier result has not been taken.
module double_ended_queue_top #(
	parameter int DEPTH = dq_pkg::DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	dq_req_if.sink      req,
	dq_rsp_if.source    rsp
);

	// Command and status bundles between the sequencer and the storage datapath.
	dq_pkg::ctrl_cmd_t cmd;
	dq_pkg::dp_sts_t   sts;

	// The sequencer owns the request handshake and steps each request through.
	dq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// The datapath holds the circular store, the pointers, the count and the
	// result register that drives the response channel.
	dq_datapath #(
		.DEPTH (DEPTH)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.req_type      (req.req_type),
		.value         (req.value),
		.out_valid     (rsp.valid),
		.out_ready     (rsp.ready),
		.removed_value (rsp.removed_value),
		.status        (rsp.status),
		.front_value   (rsp.front_value),
		.rear_value    (rsp.rear_value),
		.is_empty      (rsp.is_empty),
		.fill_count    (rsp.fill_count)
	);

endmodule

// ----- hw/rtl/dq_ctrl.sv -----
module dq_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  dq_pkg::dp_sts_t    sts,
	output dq_pkg::ctrl_cmd_t  cmd
);

	dq_pkg::state_t state_q;
	dq_pkg::state_t state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dq_pkg::S_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n  = state_q;
		in_ready = 1'b0;
		cmd      = '0;
		unique case (state_q)
			dq_pkg::S_IDLE: begin
				in_ready      = 1'b1;
				cmd.latch_req = in_valid;
				if (in_valid) begin
					state_n = dq_pkg::S_EXEC;
				end
			end
			dq_pkg::S_EXEC: begin
				cmd.exec = 1'b1;
				state_n  = dq_pkg::S_FETCH;
			end
			dq_pkg::S_FETCH: begin
				cmd.capture_removed = 1'b1;
				state_n             = dq_pkg::S_LOAD;
			end
			dq_pkg::S_LOAD: begin
				// Hold here while the previous result is still waiting.
				if (!sts.out_busy) begin
					cmd.load_out = 1'b1;
					state_n      = dq_pkg::S_IDLE;
				end
			end
			default: begin
				state_n = dq_pkg::S_IDLE;
			end
		endcase
	end

	a_accept_goes_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == dq_pkg::S_EXEC))
		else $error("accepted request did not move to execute");

	a_load_only_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> !sts.out_busy)
		else $error("output register loaded while still occupied");

	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.latch_req, cmd.exec, cmd.capture_removed, cmd.load_out}))
		else $error("more than one datapath command at once");

endmodule

// ----- hw/rtl/dq_datapath.sv -----
module dq_datapath #(
	parameter int DEPTH = dq_pkg::DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  dq_pkg::ctrl_cmd_t                 cmd,
	output dq_pkg::dp_sts_t                   sts,
	input  logic [dq_pkg::REQ_W-1:0]          req_type,
	input  logic signed [dq_pkg::DATA_W-1:0]  value,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [dq_pkg::DATA_W-1:0]  removed_value,
	output logic [dq_pkg::STAT_W-1:0]         status,
	output logic signed [dq_pkg::DATA_W-1:0]  front_value,
	output logic signed [dq_pkg::DATA_W-1:0]  rear_value,
	output logic                              is_empty,
	output logic [dq_pkg::FILL_W-1:0]         fill_count
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] i);
		return (i == LAST_IDX) ? '0 : i + AW'(1);
	endfunction

	function automatic logic [AW-1:0] wrap_dec(input logic [AW-1:0] i);
		return (i == '0) ? LAST_IDX : i - AW'(1);
	endfunction

	logic [dq_pkg::DATA_W-1:0] mem [DEPTH];

	dq_pkg::req_t              req_q;
	logic [dq_pkg::DATA_W-1:0] value_q;
	logic [AW-1:0]             front_q;
	logic [AW-1:0]             rear_q;
	logic [CW-1:0]             count_q;
	dq_pkg::status_t           status_q;
	dq_pkg::status_t           exec_status;
	logic [dq_pkg::DATA_W-1:0] rd_a_q;
	logic [dq_pkg::DATA_W-1:0] rd_b_q;
	logic [dq_pkg::DATA_W-1:0] removed_q;
	logic                      is_insert;
	logic                      wr_en;
	logic [AW-1:0]             wr_addr;
	logic [AW-1:0]             rd_addr_a;
	logic [AW-1:0]             rd_addr_b;
	logic                      out_valid_q;

	always_ff @(posedge clk) begin
		if (cmd.latch_req) begin
			req_q   <= dq_pkg::req_t'(req_type);
			value_q <= value;
		end
	end

	assign is_insert = (req_q == dq_pkg::REQ_PUSH_FRONT) || (req_q == dq_pkg::REQ_PUSH_REAR);

	always_comb begin
		exec_status = dq_pkg::ST_DONE;
		if (is_insert && (count_q == FULL_CNT)) begin
			exec_status = dq_pkg::ST_FULL;
		end else if (!is_insert && (count_q == '0)) begin
			exec_status = dq_pkg::ST_EMPTY;
		end
	end

	assign wr_en   = cmd.exec && is_insert && (exec_status == dq_pkg::ST_DONE);
	assign wr_addr = (req_q == dq_pkg::REQ_PUSH_FRONT) ? wrap_dec(front_q) : rear_q;

	// Port A reads the entry being removed during execute, the front otherwise.
	assign rd_addr_a = (cmd.exec && (req_q == dq_pkg::REQ_POP_REAR)) ? wrap_dec(rear_q) : front_q;
	assign rd_addr_b = wrap_dec(rear_q);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= value_q;
		end
		rd_a_q <= mem[rd_addr_a];
		rd_b_q <= mem[rd_addr_b];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			rear_q  <= '0;
			count_q <= '0;
		end else if (cmd.exec && (exec_status == dq_pkg::ST_DONE)) begin
			unique case (req_q)
				dq_pkg::REQ_PUSH_FRONT: begin
					front_q <= wrap_dec(front_q);
					count_q <= count_q + CW'(1);
				end
				dq_pkg::REQ_PUSH_REAR: begin
					rear_q  <= wrap_inc(rear_q);
					count_q <= count_q + CW'(1);
				end
				dq_pkg::REQ_POP_FRONT: begin
					front_q <= wrap_inc(front_q);
					count_q <= count_q - CW'(1);
				end
				dq_pkg::REQ_POP_REAR: begin
					rear_q  <= wrap_dec(rear_q);
					count_q <= count_q - CW'(1);
				end
				default: begin
					count_q <= count_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			status_q <= exec_status;
		end
		if (cmd.capture_removed) begin
			removed_q <= (!is_insert && (status_q == dq_pkg::ST_DONE)) ? rd_a_q : '0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			removed_value <= removed_q;
			status        <= status_q;
			front_value   <= (count_q == '0) ? '0 : rd_a_q;
			rear_value    <= (count_q == '0) ? '0 : rd_b_q;
			is_empty      <= (count_q == '0);
			fill_count    <= dq_pkg::FILL_W'(count_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid    = out_valid_q;
	assign sts.out_busy = out_valid_q && !out_ready;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("entry count above depth");

	a_ptr_match: assert property (@(posedge clk) disable iff (!arst_n)
		((count_q == '0) || (count_q == FULL_CNT)) == (front_q == rear_q))
		else $error("pointers disagree with entry count");

	a_reject_keeps_state: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec && (exec_status != dq_pkg::ST_DONE))
		|=> ($stable(count_q) && $stable(front_q) && $stable(rear_q)))
		else $error("rejected request changed the queue");

endmodule

// ----- tb/sv/dq_scoreboard.sv -----
`timescale 1ns / 1ps

// Tracks the deque contents from the request beats, then checks each result beat
// against the oldest outcome still owed.
module dq_scoreboard #(
	parameter int DEPTH = dq_pkg::DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	dq_req_if    req,
	dq_rsp_if    rsp,
	output int   errors,
	output int   outstanding
);
	import dq_pkg::*;

	typedef struct {
		logic signed [DATA_W-1:0] removed;
		status_t                  status;
		logic signed [DATA_W-1:0] front;
		logic signed [DATA_W-1:0] rear;
		logic                     empty;
		logic [FILL_W-1:0]        fill;
	} outcome_t;

	logic signed [DATA_W-1:0] slots [DEPTH];
	int unsigned head;
	int unsigned tail;
	int unsigned held;
	outcome_t    owed[$];

	initial errors = 0;

	function automatic int unsigned slot_after(int unsigned i);
		return (i + 1 >= DEPTH) ? 0 : i + 1;
	endfunction

	function automatic int unsigned slot_before(int unsigned i);
		return (i == 0) ? DEPTH - 1 : i - 1;
	endfunction

	// Applies one request to the shadow deque and returns the result it must produce.
	function automatic outcome_t apply_request(req_t kind, logic signed [DATA_W-1:0] data);
		outcome_t o;
		o.removed = '0;
		o.status  = ST_DONE;
		o.front   = '0;
		o.rear    = '0;
		case (kind)
			REQ_PUSH_FRONT, REQ_PUSH_REAR: begin
				if (held >= DEPTH) begin
					o.status = ST_FULL;
				end else if (kind == REQ_PUSH_FRONT) begin
					head = slot_before(head);
					slots[head] = data;
					held++;
				end else begin
					slots[tail] = data;
					tail = slot_after(tail);
					held++;
				end
			end
			default: begin
				if (held == 0) begin
					o.status = ST_EMPTY;
				end else if (kind == REQ_POP_FRONT) begin
					o.removed = slots[head];
					head = slot_after(head);
					held--;
				end else begin
					tail = slot_before(tail);
					o.removed = slots[tail];
					held--;
				end
			end
		endcase
		// Only occupied slots are read, so never-written entries stay out of the picture.
		if (held != 0) begin
			o.front = slots[head];
			o.rear  = slots[slot_before(tail)];
		end
		o.empty = (held == 0);
		o.fill  = FILL_W'(held);
		return o;
	endfunction

	task automatic compare_outcome(outcome_t want);
		if (rsp.removed_value !== want.removed) begin
			$error("removed_value: expected %0d, got %0d", want.removed, rsp.removed_value);
			errors++;
		end
		if (rsp.status !== want.status) begin
			$error("status: expected %0d, got %0d", want.status, rsp.status);
			errors++;
		end
		if (rsp.front_value !== want.front) begin
			$error("front_value: expected %0d, got %0d", want.front, rsp.front_value);
			errors++;
		end
		if (rsp.rear_value !== want.rear) begin
			$error("rear_value: expected %0d, got %0d", want.rear, rsp.rear_value);
			errors++;
		end
		if (rsp.is_empty !== want.empty) begin
			$error("is_empty: expected %0d, got %0d", want.empty, rsp.is_empty);
			errors++;
		end
		if (rsp.fill_count !== want.fill) begin
			$error("fill_count: expected %0d, got %0d", want.fill, rsp.fill_count);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head = 0;
			tail = 0;
			held = 0;
			owed.delete();
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (owed.size() == 0) begin
					$error("result beat arrived with no request outstanding");
					errors++;
				end else begin
					compare_outcome(owed.pop_front());
				end
			end
			if (req.valid && req.ready)
				owed.push_back(apply_request(req_t'(req.req_type), req.value));
		end
		outstanding = owed.size();
	end

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps

// Top of the deque testbench. It owns the clock and reset, drives request beats
// and the result-side ready, and gives the verdict. All prediction and checking
// lives in the scoreboard instance next to the block.
module tb;
	import dq_pkg::*;

	localparam int DEPTH        = DEPTH_DEF;
	localparam int RANDOM_ITEMS = 1850;
	// The slowest legal run is roughly 2000 beats, each with the longest gap and stall;
	// the limit leaves a wide margin on top of that.
	localparam int CYCLE_LIMIT  = 400000;
	// Wait after the last owed result, so that a stray result beat would still show.
	localparam int DRAIN_CYCLES = 8;

	// Bias of a stimulus phase: push-heavy phases drive the deque to full,
	// pop-heavy phases drain it to empty, mixed phases wander around the middle.
	typedef enum {
		BIAS_FILL,
		BIAS_DRAIN,
		BIAS_MIX
	} bias_t;

	logic  clk    = 1'b0;
	logic  arst_n;
	logic  calm   = 1'b0;
	bias_t bias   = BIAS_MIX;
	int    errors;
	int    outstanding;
	int    cycle_count = 0;

	dq_req_if req_ch ();
	dq_rsp_if rsp_ch ();

	double_ended_queue_top #(
		.DEPTH(DEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	dq_scoreboard #(
		.DEPTH(DEPTH)
	) scoreboard (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.errors(errors),
		.outstanding(outstanding)
	);

	always #2 clk = ~clk;

	// Hard stop in case a handshake never completes.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Number of idle cycles in front of a beat. During calm phases both sides run
	// flat out, so the block also sees long stretches at full rate.
	function automatic int draw_wait();
		return calm ? 0 : $urandom_range(0, 6);
	endfunction

	// Push or pop, front or rear, with the push share set by the phase bias.
	function automatic req_t pick_request();
		int push_pct;
		int roll;
		logic rear_side;
		case (bias)
			BIAS_FILL:  push_pct = 85;
			BIAS_DRAIN: push_pct = 15;
			default:    push_pct = 50;
		endcase
		roll = $urandom_range(0, 99);
		rear_side = 1'($urandom_range(0, 1));
		if (roll < push_pct)
			return rear_side ? REQ_PUSH_REAR : REQ_PUSH_FRONT;
		return rear_side ? REQ_POP_REAR : REQ_POP_FRONT;
	endfunction

	// Mostly uniform 32-bit values, with the signed extremes, zero and all ones mixed in now and then.
	function automatic logic signed [DATA_W-1:0] pick_value();
		case ($urandom_range(0, 15))
			0:       return 32'sh7FFF_FFFF;
			1:       return 32'sh8000_0000;
			2:       return '0;
			3:       return '1;
			default: return $urandom;
		endcase
	endfunction

	// Drives one request beat and returns at the edge where it was accepted.
	// The payload is held steady while valid is high and ready is low.
	task automatic issue(req_t kind, logic signed [DATA_W-1:0] data);
		int gap;
		gap = draw_wait();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid    <= 1'b1;
		req_ch.req_type <= kind;
		req_ch.value    <= data;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
	endtask

	// Result-side ready: a random stall before each beat, drawn before the block
	// even offers a result so that the stall lands on every phase of its work.
	initial begin
		int stall;
		rsp_ch.ready <= 1'b0;
		@(posedge clk);
		forever begin
			stall = draw_wait();
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			@(posedge clk);
			while (!rsp_ch.valid) @(posedge clk);
		end
	end

	initial begin
		int sent;
		int phase_len;
		arst_n          <= 1'b0;
		req_ch.valid    <= 1'b0;
		req_ch.req_type <= REQ_PUSH_FRONT;
		req_ch.value    <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part. Removals from an empty deque come first, at both ends.
		issue(REQ_POP_FRONT, 32'sh1234_5678);
		issue(REQ_POP_REAR, '1);
		// Signed extremes and alternating bit patterns at both ends.
		issue(REQ_PUSH_FRONT, 32'sh7FFF_FFFF);
		issue(REQ_PUSH_REAR, 32'sh8000_0000);
		issue(REQ_PUSH_FRONT, '0);
		issue(REQ_PUSH_REAR, '1);
		issue(REQ_PUSH_FRONT, 32'sh5555_5555);
		issue(REQ_PUSH_REAR, 32'shAAAA_AAAA);
		// Drain from both ends in mixed order; the front pointer has wrapped below slot zero.
		issue(REQ_POP_FRONT, '0);
		issue(REQ_POP_REAR, '0);
		issue(REQ_POP_REAR, '1);
		issue(REQ_POP_FRONT, '0);
		issue(REQ_POP_FRONT, '0);
		issue(REQ_POP_REAR, '0);
		issue(REQ_POP_FRONT, '0);
		// A single entry: front and rear values coincide.
		issue(REQ_PUSH_REAR, 32'sh0000_0001);
		issue(REQ_POP_FRONT, '0);
		issue(REQ_PUSH_FRONT, -32'sd1000);
		issue(REQ_POP_REAR, '0);
		issue(REQ_POP_REAR, '0);

		// Random part in phases of varying bias and idling. Push-heavy phases run
		// into the full deque, so dropped inserts and pointer wrap get exercised
		// repeatedly; pop-heavy phases do the same for removals on empty.
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			phase_len = $urandom_range(60, 140);
			case ($urandom_range(0, 2))
				0:       bias = BIAS_FILL;
				1:       bias = BIAS_DRAIN;
				default: bias = BIAS_MIX;
			endcase
			calm = ($urandom_range(0, 3) == 0);
			repeat (phase_len) begin
				issue(pick_request(), pick_value());
				sent++;
			end
		end
		req_ch.valid <= 1'b0;

		// Let the scoreboard see the last request, wait for every owed result, then
		// wait DRAIN_CYCLES longer so that any stray beat from the block would show.
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (errors == 0 && outstanding == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
